// ===== rtl/mqttd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mqttd_pkg
// Types and constants shared by the MQTT packet deframer modules.
// ----------------------------------------------------------------------------
package mqttd_pkg;

    localparam int unsigned MAX_LENGTH_BYTES = 4;
    localparam int unsigned LEN_W            = 28;

    localparam logic [1:0] ROLE_TYPE    = 2'd0;
    localparam logic [1:0] ROLE_LENGTH  = 2'd1;
    localparam logic [1:0] ROLE_BODY    = 2'd2;
    localparam logic [1:0] ROLE_DISCARD = 2'd3;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_MALFORMED = 2'd1;
    localparam logic [1:0] ERR_WRONG_TYPE = 2'd2;

    typedef struct packed {
        logic [3:0] expected_type;
        logic       frame_start;
        logic [7:0] data_byte;
    } t_item;

    typedef struct packed {
        logic [1:0]       error_code;
        logic             end_of_packet;
        logic             header_done;
        logic [2:0]       header_length;
        logic [LEN_W-1:0] remaining_length;
        logic             dup_flag;
        logic             retain_flag;
        logic [1:0]       qos_level;
        logic [3:0]       packet_type;
        logic [1:0]       byte_role;
        logic [7:0]       byte_echo;
    } t_result;

endpackage
`default_nettype wire

// ===== rtl/mqttd_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mqttd_stage
// One register stage of the stream path with valid and ready handshake.
// ----------------------------------------------------------------------------
module mqttd_stage #(
    parameter int unsigned WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic [WIDTH-1:0] i_in_data,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output logic [WIDTH-1:0]      o_out_data
);

    logic             r_valid;
    logic [WIDTH-1:0] r_data;

    assign o_in_ready  = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_data <= i_in_data;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/mqttd_decode.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mqttd_decode
// Fixed-header state machine: classifies each byte and builds its result.
// ----------------------------------------------------------------------------
module mqttd_decode (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_advance,
    input  wire mqttd_pkg::t_item i_item,
    output mqttd_pkg::t_result   o_result
);

    typedef enum logic [1:0] {
        PH_TYPE,
        PH_LEN,
        PH_BODY,
        PH_DISCARD
    } t_phase;

    localparam int unsigned LW = mqttd_pkg::LEN_W;

    t_phase          r_phase,    n_phase;
    logic [2:0]      r_len_cnt,  n_len_cnt;
    logic [LW-1:0]   r_acc,      n_acc;
    logic [LW-1:0]   r_body_left, n_body_left;
    logic [7:0]      r_taf,      n_taf;
    logic            r_mismatch, n_mismatch;

    logic [LW-1:0]   shifted;
    logic [1:0]      role;
    logic            hdr_done;
    logic            eop;
    logic [1:0]      err;

    always_comb begin
        unique case (r_len_cnt[1:0])
            2'd0: shifted = {{(LW-7){1'b0}}, i_item.data_byte[6:0]};
            2'd1: shifted = {{(LW-14){1'b0}}, i_item.data_byte[6:0], 7'd0};
            2'd2: shifted = {{(LW-21){1'b0}}, i_item.data_byte[6:0], 14'd0};
            default: shifted = {i_item.data_byte[6:0], 21'd0};
        endcase
    end

    always_comb begin
        n_phase     = r_phase;
        n_len_cnt   = r_len_cnt;
        n_acc       = r_acc;
        n_body_left = r_body_left;
        n_taf       = r_taf;
        n_mismatch  = r_mismatch;
        role        = mqttd_pkg::ROLE_DISCARD;
        hdr_done    = 1'b0;
        eop         = 1'b0;
        err         = mqttd_pkg::ERR_NONE;

        priority if (i_item.frame_start || r_phase == PH_TYPE) begin
            n_taf       = i_item.data_byte;
            n_len_cnt   = 3'd0;
            n_acc       = '0;
            n_body_left = '0;
            n_mismatch  = (i_item.expected_type != 4'd0)
                       && (i_item.expected_type != i_item.data_byte[7:4]);
            n_phase     = PH_LEN;
            role        = mqttd_pkg::ROLE_TYPE;
        end else if (r_phase == PH_LEN) begin
            role      = mqttd_pkg::ROLE_LENGTH;
            n_acc     = r_acc + shifted;
            n_len_cnt = r_len_cnt + 3'd1;
            priority if (i_item.data_byte[7]) begin
                if (n_len_cnt >= 3'(mqttd_pkg::MAX_LENGTH_BYTES)) begin
                    n_phase = PH_DISCARD;
                    err     = mqttd_pkg::ERR_MALFORMED;
                end
            end else if (r_mismatch) begin
                n_phase = PH_DISCARD;
                err     = mqttd_pkg::ERR_WRONG_TYPE;
            end else if (n_acc == '0) begin
                n_phase  = PH_TYPE;
                hdr_done = 1'b1;
                eop      = 1'b1;
            end else begin
                n_body_left = n_acc;
                n_phase     = PH_BODY;
                hdr_done    = 1'b1;
            end
        end else if (r_phase == PH_BODY) begin
            role = mqttd_pkg::ROLE_BODY;
            if (r_body_left != '0) begin
                n_body_left = r_body_left - LW'(1);
            end
            eop = (n_body_left == '0);
            if (eop) begin
                n_phase = PH_TYPE;
            end
        end else begin
            role = mqttd_pkg::ROLE_DISCARD;
        end
    end

    always_comb begin
        o_result.byte_echo        = i_item.data_byte;
        o_result.byte_role        = role;
        o_result.packet_type      = n_taf[7:4];
        o_result.qos_level        = n_taf[2:1];
        o_result.retain_flag      = n_taf[0];
        o_result.dup_flag         = n_taf[3];
        o_result.remaining_length = n_acc;
        o_result.header_length    = n_len_cnt + 3'd1;
        o_result.header_done      = hdr_done;
        o_result.end_of_packet    = eop;
        o_result.error_code       = err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_TYPE;
            r_len_cnt   <= 3'd0;
            r_acc       <= '0;
            r_body_left <= '0;
            r_taf       <= 8'd0;
            r_mismatch  <= 1'b0;
        end else if (i_advance) begin
            r_phase     <= n_phase;
            r_len_cnt   <= n_len_cnt;
            r_acc       <= n_acc;
            r_body_left <= n_body_left;
            r_taf       <= n_taf;
            r_mismatch  <= n_mismatch;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/mqtt_packet_deframer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mqtt_packet_deframer
// Splits an MQTT byte stream into packets and decodes each fixed header.
//
// The block takes one stream byte per clock while ready is high and returns
// one result per byte; each byte passes through the input register, then
// the header state machine and the result register. Throughput is one byte
// per cycle while downstream keeps up, as the phase, length and body
// counters update once per byte; ready falls only while the result register
// holds a request that downstream has not taken. A byte flagged as frame
// start always opens a new packet. After a malformed length or a wrong packet
// type, bytes come back marked as discarded until the next frame start.
// ----------------------------------------------------------------------------
module mqtt_packet_deframer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [7:0] data_byte, [11:8] expected_type, [15:12] zero
    input  wire logic [15:0] s_axis_tdata,
    // [0] frame_start
    input  wire logic [0:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] byte_echo, [11:8] packet_type, [13:12] qos_level, [14] retain_flag,
    // [15] dup_flag, [43:16] remaining_length, [46:44] header_length,
    // [47] header_done, [49:48] error_code, [55:50] zero
    output logic [55:0]      m_axis_tdata,
    // [1:0] byte_role
    output logic [1:0]       m_axis_tuser,
    output logic             m_axis_tlast
);

    localparam int unsigned ITEM_W = $bits(mqttd_pkg::t_item);
    localparam int unsigned RES_W  = $bits(mqttd_pkg::t_result);

    mqttd_pkg::t_item   in_item;
    mqttd_pkg::t_item   held_item;
    mqttd_pkg::t_result result;
    mqttd_pkg::t_result out_res;
    logic [ITEM_W-1:0]  held_vec;
    logic [RES_W-1:0]   out_vec;
    logic               held_valid;
    logic               out_ready;

    always_comb begin
        in_item.data_byte     = s_axis_tdata[7:0];
        in_item.expected_type = s_axis_tdata[11:8];
        in_item.frame_start   = s_axis_tuser[0];
    end

    mqttd_stage #(
        .WIDTH(ITEM_W)
    ) u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_in_data  (in_item),
        .o_out_valid(held_valid),
        .i_out_ready(out_ready),
        .o_out_data (held_vec)
    );

    assign held_item = mqttd_pkg::t_item'(held_vec);

    mqttd_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_advance(held_valid && out_ready),
        .i_item   (held_item),
        .o_result (result)
    );

    mqttd_stage #(
        .WIDTH(RES_W)
    ) u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (held_valid),
        .o_in_ready (out_ready),
        .i_in_data  (result),
        .o_out_valid(m_axis_tvalid),
        .i_out_ready(m_axis_tready),
        .o_out_data (out_vec)
    );

    assign out_res = mqttd_pkg::t_result'(out_vec);

    always_comb begin
        m_axis_tdata = {6'd0,
                        out_res.error_code,
                        out_res.header_done,
                        out_res.header_length,
                        out_res.remaining_length,
                        out_res.dup_flag,
                        out_res.retain_flag,
                        out_res.qos_level,
                        out_res.packet_type,
                        out_res.byte_echo};
        m_axis_tuser = out_res.byte_role;
        m_axis_tlast = out_res.end_of_packet;
    end

endmodule
`default_nettype wire
